// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file ppm_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, masked while rst_n is low.
`define PPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ppm assertion failed");

// Concurrent check on the rising edge of clk, live during reset too.
`define PPM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("ppm assertion failed during or after reset");

`endif

// ===== hw/rtl/ppm_pkg.sv =====
// Package for the peak program meter: widths, constants, register indexes, types.
// No dependencies.
`default_nettype none

package ppm_pkg;

  localparam int CHANNELS  = 8;
  localparam int CHAN_W    = 3;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_W  = 24;
  localparam int MAG_W     = 23;
  localparam int COEF_W    = 25;
  localparam int ENV_W     = 48;
  localparam int FRAC_W    = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [COEF_W-1:0] COEF_ONE           = 25'h100_0000;
  localparam logic [COEF_W-1:0] ALPHA_ATTACK_RST   = 25'd76722;
  localparam logic [COEF_W-1:0] ALPHA_RELEASE_RST  = 25'd513;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ATTACK  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_RELEASE = 1'd1;

  typedef struct packed {
    logic [COEF_W-1:0] attack;
    logic [COEF_W-1:0] release_c;
  } coef_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppm_env_update.sv =====
// Envelope update for one sample: rectify, pick attack or release, blend.
// Depends on ppm_pkg.
`default_nettype none

module ppm_env_update import ppm_pkg::*; (
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic [ENV_W-1:0]    env,
  input  wire coef_t               coef,
  output logic      [ENV_W-1:0]    env_nxt
);

  logic [SAMPLE_W-1:0] neg;
  logic [MAG_W-1:0]    mag;
  logic                decay;
  logic [COEF_W-1:0]   att_c;
  logic [COEF_W-1:0]   rel_c;
  logic [COEF_W-1:0]   keep_c;
  logic [48:0]         prod_hi;
  logic [48:0]         prod_lo;
  logic [47:0]         prod_mag;
  logic [49:0]         sum;

  // Rectify; the most negative code saturates to full scale.
  assign neg = SAMPLE_W'(~sample + 1'b1);
  always_comb begin
    if (!sample[SAMPLE_W-1]) begin
      mag = sample[MAG_W-1:0];
    end else if (neg[SAMPLE_W-1]) begin
      mag = {MAG_W{1'b1}};
    end else begin
      mag = neg[MAG_W-1:0];
    end
  end

  // Coefficients above one act as one.
  assign att_c = (coef.attack > COEF_ONE) ? COEF_ONE : coef.attack;
  assign rel_c = (coef.release_c > COEF_ONE) ? COEF_ONE : coef.release_c;

  // Ties go to attack.
  assign decay  = {1'b0, mag, {FRAC_W{1'b0}}} < env;
  assign keep_c = decay ? COEF_ONE - rel_c : COEF_ONE - att_c;

  // Split env into integer and fraction halves to keep multipliers narrow.
  assign prod_hi  = 49'(keep_c) * 49'(env[ENV_W-1:FRAC_W]);
  assign prod_lo  = 49'(keep_c) * 49'(env[FRAC_W-1:0]);
  assign prod_mag = decay ? 48'd0 : 48'(att_c) * 48'(mag);

  assign sum     = 50'(prod_hi) + 50'(prod_lo[48:FRAC_W]) + 50'(prod_mag);
  assign env_nxt = sum[ENV_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/ppm_peak_meter.sv =====
// Peak program meter: a request enters the input register; a block-end result then
// loads the output register, held while out_ready is low. A new request is taken
// every cycle unless the update stage stalls a block-end result on a full, unread output.
// Per-channel envelope/peak state lives in flops beside the update logic.
// Synchronous active-low reset clears envelopes, peaks, valids and restores
// the default attack and release coefficients.
`default_nettype none

module ppm_peak_meter import ppm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_wdata,
  // sample requests
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CHAN_W-1:0]    in_channel,
  input  wire logic [SAMPLE_W-1:0]  in_sample,
  input  wire logic                 in_block_end,
  // peak results
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [CHAN_W-1:0]    out_peak_channel,
  output logic      [MAG_W-1:0]     out_peak
);

  // Coefficient registers
  coef_t coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.attack    <= ALPHA_ATTACK_RST;
      coef_r.release_c <= ALPHA_RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA_ATTACK:  coef_r.attack    <= cfg_wdata;
        REG_ALPHA_RELEASE: coef_r.release_c <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: holds one request while its channel state is updated.
  logic                s1_vld_r;
  logic [CHAN_W-1:0]   s1_chan_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                s1_last_r;

  logic s1_in_range;
  logic s1_result;
  logic s1_adv;
  logic s1_commit;

  // A channel beyond the state arrays is dropped without a result.
  assign s1_in_range = 32'(s1_chan_r) < CHANNELS;
  assign s1_result   = s1_vld_r && s1_in_range && s1_last_r;
  // Stall only when a result would land on an unread output register.
  assign s1_adv      = !(s1_result && out_valid && !out_ready);
  assign s1_commit   = s1_vld_r && s1_in_range && s1_adv;
  assign in_ready    = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_chan_r   <= in_channel;
      s1_sample_r <= in_sample;
      s1_last_r   <= in_block_end;
    end
  end

  // Per-channel state, read at the request's channel.
  logic [ENV_W-1:0]    env_r  [CHANNELS];
  logic [MAG_W-1:0]    peak_r [CHANNELS];
  logic [CH_IDX_W-1:0] ch_idx;
  logic [ENV_W-1:0]    env_cur;
  logic [ENV_W-1:0]    env_nxt;
  logic [MAG_W-1:0]    ipart;
  logic [MAG_W-1:0]    peak_nxt;

  assign ch_idx  = CH_IDX_W'(s1_chan_r);
  assign env_cur = env_r[ch_idx];

  ppm_env_update u_env (
    .sample  (s1_sample_r),
    .env     (env_cur),
    .coef    (coef_r),
    .env_nxt (env_nxt)
  );

  // Integer part of the new envelope joins the running block peak.
  assign ipart    = env_nxt[FRAC_W +: MAG_W];
  assign peak_nxt = (ipart > peak_r[ch_idx]) ? ipart : peak_r[ch_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        env_r[i]  <= '0;
        peak_r[i] <= '0;
      end
    end else if (s1_commit) begin
      env_r[ch_idx]  <= env_nxt;
      // Block end reports the peak and starts the next block from zero.
      peak_r[ch_idx] <= s1_last_r ? '0 : peak_nxt;
    end
  end

  // Output register
  logic              out_valid_r;
  logic [CHAN_W-1:0] out_chan_r;
  logic [MAG_W-1:0]  out_peak_r;
  logic              out_load;

  assign out_load = s1_result && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan_r <= s1_chan_r;
      out_peak_r <= peak_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_peak_channel = out_chan_r;
  assign out_peak         = out_peak_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ppm_checker.sv =====
// Port-level checks for ppm_peak_meter, bound to the top level.
// Depends on ppm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ppm_checker import ppm_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [CHAN_W-1:0]    out_peak_channel,
  input wire logic [MAG_W-1:0]     out_peak
);

  // A stalled result holds valid and payload.
  `PPM_ASSERT(a_out_hold, out_valid && !out_ready |=> $stable({out_valid, out_peak_channel, out_peak}))

  // A fresh result follows a request taken into the input register before it.
  `PPM_ASSERT(a_out_cause, $rose(out_valid) |-> $past(in_valid && in_ready, 2))

  // A draining output never blocks the input side.
  `PPM_ASSERT(a_ready_flow, out_ready |-> in_ready)

  // Reset empties the output register.
  `PPM_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid)

endmodule

bind ppm_peak_meter ppm_checker u_ppm_checker (.*);

`default_nettype wire
